/* hdl/hsb_pkg.sv */
// ----------------------------------------------------------------------------
// hsb_pkg: shared types and constants of the bucketed hash set
// Operation and status codes, field widths, default geometry, control states.
// ----------------------------------------------------------------------------
package hsb_pkg;

    localparam int KEY_W       = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;

    // default geometry
    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // control states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_LOOK
    } state_t;

endpackage

/* hdl/hsb_if.sv */
// ----------------------------------------------------------------------------
// hsb_if: request and response channels of the bucketed hash set
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hsb_req_if import hsb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface hsb_rsp_if import hsb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

/* hdl/hash_set_bucketed.sv */
// ----------------------------------------------------------------------------
// hash_set_bucketed: integer-key hash set with bounded buckets
// Insert, remove or lookup of a 32-bit key; one bucket row per RAM entry.
// ----------------------------------------------------------------------------
//  channel | dir | fields              | handshake
//  req     | in  | func[1:0] key[31:0] | valid/ready
//  rsp     | out | found status[1:0]   | valid/ready
//
// An item passes the bucket index, the row read, and the compare and
// write-back; when BUCKETS is not a power of two the bucket index is a
// reciprocal multiply and correction. After reset a clearing pass writes
// every bucket row before the first item is taken. The result register
// lets the next item in while a result still waits; a stalled response
// holds only the compare stage.
// ----------------------------------------------------------------------------
module hash_set_bucketed import hsb_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hsb_req_if.sink    req,
    hsb_rsp_if.source  rsp
);

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ROW_W = WAYS * (KEY_W + 1);
    localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [BW-1:0]       bucket_reg;
    logic                clr_reg;
    logic [BW-1:0]       clr_cnt_reg;
    logic                out_valid_reg;
    logic                found_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                accept;
    logic                finish;
    logic                mod_done;
    logic [BW-1:0]       mod_rem;
    logic                ram_we;
    logic [BW-1:0]       ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [ROW_W-1:0]    ram_rdata;

    logic [WAYS-1:0][KEY_W-1:0] row_keys;
    logic [WAYS-1:0]            row_valid;
    logic [WAYS-1:0][KEY_W-1:0] new_keys;
    logic [WAYS-1:0]            new_valid;
    logic                       m_found;
    logic [STATUS_W-1:0]        m_status;

    assign row_keys  = ram_rdata[WAYS*KEY_W-1:0];
    assign row_valid = ram_rdata[ROW_W-1:WAYS*KEY_W];

    // bucket index
    hsb_mod #(.BUCKETS(BUCKETS)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (req.key),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // bucket rows: valid bits over keys
    hsb_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (mod_rem),
        .rdata (ram_rdata)
    );

    hsb_match #(.WAYS(WAYS)) u_match (
        .row_keys  (row_keys),
        .row_valid (row_valid),
        .func      (func_reg),
        .key       (key_reg),
        .found     (m_found),
        .status    (m_status),
        .new_keys  (new_keys),
        .new_valid (new_valid)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept)   state_next = S_HASH;
            S_HASH:  if (mod_done) state_next = S_LOOK;
            S_LOOK:  if (finish)   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = bucket_reg;
        ram_wdata = {new_valid, new_keys};
        finish    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = !clr_reg;
                if (clr_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = clr_cnt_reg;
                    ram_wdata = '0;
                end
            end
            S_HASH:
            begin
                ram_re = mod_done;
            end
            S_LOOK:
            begin
                finish = !out_valid_reg || rsp.ready;
                ram_we = finish;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // clearing pass over all rows
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            key_reg  <= req.key;
        end
        if (ram_re)
        begin
            bucket_reg <= mod_rem;
        end
        if (finish)
        begin
            found_reg  <= m_found;
            status_reg <= m_status;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;

endmodule

/* hdl/hsb_ram.sv */
// ----------------------------------------------------------------------------
// hsb_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module hsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/hsb_mod.sv */
// ----------------------------------------------------------------------------
// hsb_mod: bucket index unit, key modulo BUCKETS
// Power-of-two bucket counts register the low key bits. Other counts pass
// through registered steps: a reciprocal multiply gives a quotient estimate
// at most one low, a multiply and subtract gives a partial remainder below
// twice the count, and one compare and subtract finishes it.
// ----------------------------------------------------------------------------
module hsb_mod import hsb_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BW-1:0]    rem
);

    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic          done_reg;
    logic [BW-1:0] rem_reg;

    assign done = done_reg;
    assign rem  = rem_reg;

    if (IS_POW2)
    begin : g_pow2
        // low bits of the key are the bucket
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                if (BUCKETS == 1)
                begin
                    rem_reg <= '0;
                end
                else
                begin
                    rem_reg <= key[BW-1:0];
                end
            end
        end
    end
    else
    begin : g_recip
        // floor(2^(KEY_W+SH) / BUCKETS) fits KEY_W bits as BUCKETS > 2^SH
        localparam int               SH    = BW - 1;
        localparam int               QW    = KEY_W - SH;
        localparam logic [KEY_W-1:0] RECIP =
            KEY_W'((64'd1 << (KEY_W + SH)) / 64'(BUCKETS));
        localparam logic [KEY_W-1:0] BKT_K = KEY_W'(BUCKETS);
        localparam logic [BW:0]      BKT_V = (BW + 1)'(BUCKETS);

        logic                 v1_reg;
        logic                 v2_reg;
        logic [2*KEY_W-1:0]   prod;
        logic [QW-1:0]        quot_reg;
        logic [KEY_W-1:0]     key_reg;
        logic [KEY_W-1:0]     diff;
        logic [BW:0]          part_reg;

        // quotient estimate and partial remainder
        assign prod = {{KEY_W{1'b0}}, key} * {{KEY_W{1'b0}}, RECIP};
        assign diff = key_reg - KEY_W'(quot_reg) * BKT_K;

        // stage valids
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v1_reg   <= 1'b0;
                v2_reg   <= 1'b0;
                done_reg <= 1'b0;
            end
            else
            begin
                v1_reg   <= start;
                v2_reg   <= v1_reg;
                done_reg <= v2_reg;
            end
        end

        // estimate, partial remainder, final correction
        always_ff @(posedge clk)
        begin
            if (start)
            begin
                quot_reg <= prod[2*KEY_W-1:KEY_W+SH];
                key_reg  <= key;
            end
            if (v1_reg)
            begin
                part_reg <= diff[BW:0];
            end
            if (v2_reg)
            begin
                if (part_reg >= BKT_V)
                begin
                    rem_reg <= BW'(part_reg - BKT_V);
                end
                else
                begin
                    rem_reg <= part_reg[BW-1:0];
                end
            end
        end
    end

endmodule

/* hdl/hsb_match.sv */
// ----------------------------------------------------------------------------
// hsb_match: way compare and row update of one bucket
// Finds the first matching way and the first free way, forms the result
// and the row to write back.
// ----------------------------------------------------------------------------
module hsb_match import hsb_pkg::*; #(
    parameter int WAYS = WAYS_DEF
) (
    input  logic [WAYS-1:0][KEY_W-1:0] row_keys,
    input  logic [WAYS-1:0]            row_valid,
    input  logic [FUNC_W-1:0]          func,
    input  logic [KEY_W-1:0]           key,
    output logic                       found,
    output logic [STATUS_W-1:0]        status,
    output logic [WAYS-1:0][KEY_W-1:0] new_keys,
    output logic [WAYS-1:0]            new_valid
);

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0] match;
    logic            hit;
    logic            have_free;
    logic [WW-1:0]   hit_way;
    logic [WW-1:0]   free_way;

    // per-way compare, only valid ways count
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = row_valid[w] && (row_keys[w] == key);
        end
    end

    // lowest matching way and lowest free way
    always_comb
    begin
        hit       = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && match[w])
            begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
            if (!have_free && !row_valid[w])
            begin
                have_free = 1'b1;
                free_way  = WW'(w);
            end
        end
    end

    // result and updated row
    always_comb
    begin
        new_keys  = row_keys;
        new_valid = row_valid;
        status    = ST_DONE;
        unique case (func)
            FN_INSERT:
            begin
                if (!hit)
                begin
                    if (have_free)
                    begin
                        new_keys[free_way]  = key;
                        new_valid[free_way] = 1'b1;
                    end
                    else
                    begin
                        status = ST_FULL;
                    end
                end
            end
            FN_REMOVE:
            begin
                if (hit)
                begin
                    new_valid[hit_way] = 1'b0;
                end
                else
                begin
                    status = ST_ABSENT;
                end
            end
            default:
            begin
                // lookup and the unused code change nothing
                status = ST_DONE;
            end
        endcase
    end

    assign found = hit;

endmodule
